@@ rtl/ocvm_pkg.sv @@
// ----------------------------------------------------------------------------
// ocvm_pkg
// Shared constants, types and helpers for the orbit camera view matrix block.
// ----------------------------------------------------------------------------
package ocvm_pkg;

    // unit quantities are Q30
    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // angle scaling: x = a * PI_Q30 / 18000, split as a*QUO + (a*REM + 9000) / 18000
    localparam logic [17:0] ANG_QUO = 18'(PI_Q30 / 32'd18000);
    localparam logic [12:0] ANG_REM = 13'(PI_Q30 - 32'(ANG_QUO) * 32'd18000);
    localparam int          ANG_SH  = 41;
    localparam logic [26:0] ANG_MUL = 27'(((64'd1 << ANG_SH) + 64'd17999) / 64'd18000);

    // horner divisors as exact reciprocal multipliers for 32-bit dividends
    localparam int HORN_STEPS = 5;
    localparam logic [32:0] HORN_MUL [HORN_STEPS] = '{
        33'(((66'd1 << 39) + 66'd109) / 66'd110),
        33'(((66'd1 << 39) + 66'd71) / 66'd72),
        33'(((66'd1 << 38) + 66'd41) / 66'd42),
        33'(((66'd1 << 37) + 66'd19) / 66'd20),
        33'(((66'd1 << 35) + 66'd5) / 66'd6)
    };
    localparam int HORN_SH [HORN_STEPS] = '{39, 39, 38, 37, 35};

    // register map (word index)
    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_TARGET_Y = 2'd1;
    localparam logic [1:0] REG_TARGET_Z = 2'd2;

    localparam logic [1:0] ROW_LAST = 2'd3;

    // stored matrix, only the elements that vary
    typedef struct packed {
        logic signed [31:0] unit_cy;
        logic signed [31:0] unit_ux;
        logic signed [31:0] unit_dx;
        logic signed [31:0] unit_cp;
        logic signed [31:0] unit_sp;
        logic signed [31:0] unit_nsy;
        logic signed [31:0] unit_uz;
        logic signed [31:0] unit_dz;
        logic signed [31:0] tr_x;
        logic signed [31:0] tr_y;
        logic signed [31:0] tr_z;
    } mat_t;

    // round a Q60 product to Q30, half up
    function automatic logic signed [31:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = (v + 64'sd536870912) >>> 30;
        return w[31:0];
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ocvm_sine.sv @@
// ----------------------------------------------------------------------------
// ocvm_sine
// Pipelined sine of an angle in hundredths of a degree, Q30 result.
// ----------------------------------------------------------------------------
module ocvm_sine (
    input  logic               aclk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [31:0] sine
);

    localparam int NS = ocvm_pkg::HORN_STEPS;

    logic [13:0]        qa_reg;
    logic               neg_reg;
    logic [31:0]        aq_reg;
    logic [31:0]        aq2_reg;
    logic [25:0]        u_reg;
    logic [52:0]        pmx_reg;
    logic [30:0]        x_reg;
    logic [61:0]        px_reg;
    logic [62:0]        pa_reg [NS];
    logic [65:0]        pm_reg [NS];
    logic [31:0]        x2_dly_reg [2*NS-2];
    logic [30:0]        x_dly_reg [2*NS+1];
    logic               neg_dly_reg [15];
    logic [61:0]        ps_reg;
    logic signed [31:0] s_reg;

    logic [13:0]        qa_next;
    logic               neg_next;
    logic [31:0]        x2_in [NS];
    logic [30:0]        t_in [NS];
    logic [30:0]        t_fin;

    // quadrant fold to 0..90 degrees
    always_comb begin
        priority if (angle < 16'd9000) begin
            qa_next  = angle[13:0];
            neg_next = 1'b0;
        end else if (angle < 16'd18000) begin
            qa_next  = 14'(16'd18000 - angle);
            neg_next = 1'b0;
        end else if (angle < 16'd27000) begin
            qa_next  = 14'(angle - 16'd18000);
            neg_next = 1'b1;
        end else begin
            qa_next  = 14'(16'd36000 - angle);
            neg_next = 1'b1;
        end
    end

    // horner step operands
    always_comb begin
        x2_in[0] = px_reg[61:30];
        t_in[0]  = ocvm_pkg::Q30_ONE[30:0];
        for (int i = 1; i < NS; i++) begin
            x2_in[i] = x2_dly_reg[2*i-1];
            t_in[i]  = ocvm_pkg::Q30_ONE[30:0]
                       - 31'(pm_reg[i-1] >> ocvm_pkg::HORN_SH[i-1]);
        end
        t_fin = ocvm_pkg::Q30_ONE[30:0] - 31'(pm_reg[NS-1] >> ocvm_pkg::HORN_SH[NS-1]);
    end

    // pipeline stages
    always_ff @(posedge aclk) begin
        if (en) begin
            qa_reg  <= qa_next;
            neg_reg <= neg_next;
            // angle in radians
            aq_reg  <= 32'(qa_reg) * 32'(ocvm_pkg::ANG_QUO);
            u_reg   <= 26'(26'(qa_reg) * 26'(ocvm_pkg::ANG_REM) + 26'd9000);
            pmx_reg <= 53'(u_reg) * 53'(ocvm_pkg::ANG_MUL);
            aq2_reg <= aq_reg;
            x_reg   <= 31'(aq2_reg + 32'(pmx_reg >> ocvm_pkg::ANG_SH));
            // square, then horner over the odd series
            px_reg  <= 62'(x_reg) * 62'(x_reg);
            for (int i = 0; i < NS; i++) begin
                pa_reg[i] <= 63'(x2_in[i]) * 63'(t_in[i]);
                pm_reg[i] <= 66'(pa_reg[i][61:30]) * 66'(ocvm_pkg::HORN_MUL[i]);
            end
            x2_dly_reg[0] <= px_reg[61:30];
            for (int k = 1; k < 2*NS-2; k++) begin
                x2_dly_reg[k] <= x2_dly_reg[k-1];
            end
            x_dly_reg[0] <= x_reg;
            for (int k = 1; k < 2*NS+1; k++) begin
                x_dly_reg[k] <= x_dly_reg[k-1];
            end
            neg_dly_reg[0] <= neg_reg;
            for (int k = 1; k < 15; k++) begin
                neg_dly_reg[k] <= neg_dly_reg[k-1];
            end
            ps_reg <= 62'(x_dly_reg[2*NS]) * 62'(t_fin);
            // sign restore
            s_reg  <= neg_dly_reg[14] ? 32'sd0 - $signed(ps_reg[61:30])
                                      : $signed(ps_reg[61:30]);
        end
    end

    assign sine = s_reg;

endmodule

@@ rtl/orbit_camera_view_matrix.sv @@
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix
// Look-at view matrix of an orbiting camera, four Q rows per camera update.
// ----------------------------------------------------------------------------
// channel  | direction | handshake        | payload
// s_       | in        | s_valid/s_ready  | yaw, pitch, radius
// m_       | out       | m_valid/m_ready  | row index, four elements, last row
// apb      | in/out    | psel/penable     | target x/y/z registers
//
// An accepted update passes the input, sine and product stages before its
// first row; rows follow one per cycle while m_ready is high. A new update
// can enter every cycle while s_ready is high; the four-row serializer sets
// the sustained rate. Synchronous reset clears valid bits and registers only.
// A full last stage and busy serializer hold the pipeline and drop s_ready.
// ----------------------------------------------------------------------------
module orbit_camera_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // update input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_yaw_angle,
    input  logic signed [14:0] s_pitch_angle,
    input  logic [30:0]        s_orbit_radius,
    // matrix rows
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_row_index,
    output logic signed [31:0] m_elem0,
    output logic signed [31:0] m_elem1,
    output logic signed [31:0] m_elem2,
    output logic signed [31:0] m_elem3,
    output logic               m_last_row,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int          LAST    = 22;
    localparam int          USH     = 30 - FRAC_BITS;
    localparam logic signed [32:0] UHALF = 33'sd1 <<< (USH - 1);
    localparam logic [30:0] RAD_MIN = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [31:0] ONE_F = 32'sd1 <<< FRAC_BITS;

    // round a Q30 unit value to the output format
    function automatic logic signed [31:0] unit_q(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = (33'(v) + UHALF) >>> USH;
        return w[31:0];
    endfunction

    // configuration registers
    logic signed [31:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            tgt_z_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                ocvm_pkg::REG_TARGET_X: tgt_x_reg <= pwdata;
                ocvm_pkg::REG_TARGET_Y: tgt_y_reg <= pwdata;
                ocvm_pkg::REG_TARGET_Z: tgt_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            ocvm_pkg::REG_TARGET_X: prdata = tgt_x_reg;
            ocvm_pkg::REG_TARGET_Y: prdata = tgt_y_reg;
            ocvm_pkg::REG_TARGET_Z: prdata = tgt_z_reg;
            default:                prdata = '0;
        endcase
    end

    // pipeline control
    logic [LAST:0] vld_reg;
    logic          en;
    logic          ser_vld_reg;
    logic [1:0]    row_reg;
    logic          ser_done, ser_free, ser_load;

    assign ser_done = ser_vld_reg && m_ready && (row_reg == ocvm_pkg::ROW_LAST);
    assign ser_free = !ser_vld_reg || ser_done;
    assign en       = !vld_reg[LAST] || ser_free;
    assign ser_load = vld_reg[LAST] && ser_free;
    assign s_ready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_valid};
        end
    end

    // input conditioning: wrap yaw, clamp pitch and radius
    logic signed [16:0] yaw_w, pit_w;
    logic [16:0]        ya_n, yc_n, pa_n, pc_n;

    always_comb begin
        yaw_w = 17'(s_yaw_angle);
        ya_n  = (yaw_w < 0) ? 17'(yaw_w + 17'sd36000) : 17'(yaw_w);
        yc_n  = (ya_n + 17'd9000 >= 17'd36000) ? ya_n + 17'd9000 - 17'd36000
                                               : ya_n + 17'd9000;
        pit_w = 17'(s_pitch_angle);
        priority if (pit_w > 17'sd8900) begin
            pit_w = 17'sd8900;
        end else if (pit_w < -17'sd8900) begin
            pit_w = -17'sd8900;
        end else begin
            pit_w = pit_w;
        end
        pa_n = (pit_w < 0) ? 17'(pit_w + 17'sd36000) : 17'(pit_w);
        pc_n = (pa_n + 17'd9000 >= 17'd36000) ? pa_n + 17'd9000 - 17'd36000
                                              : pa_n + 17'd9000;
    end

    logic [15:0] ya_reg, yc_reg, pa_reg, pc_reg;
    logic [30:0] rad_reg [LAST];

    always_ff @(posedge aclk) begin
        if (en) begin
            ya_reg     <= ya_n[15:0];
            yc_reg     <= yc_n[15:0];
            pa_reg     <= pa_n[15:0];
            pc_reg     <= pc_n[15:0];
            rad_reg[0] <= (s_orbit_radius < RAD_MIN) ? RAD_MIN : s_orbit_radius;
            for (int k = 1; k < LAST; k++) begin
                rad_reg[k] <= rad_reg[k-1];
            end
        end
    end

    // four sine units
    logic signed [31:0] sy, cy, sp, cp;

    ocvm_sine u_sin_yaw (.aclk(aclk), .en(en), .angle(ya_reg), .sine(sy));
    ocvm_sine u_cos_yaw (.aclk(aclk), .en(en), .angle(yc_reg), .sine(cy));
    ocvm_sine u_sin_pit (.aclk(aclk), .en(en), .angle(pa_reg), .sine(sp));
    ocvm_sine u_cos_pit (.aclk(aclk), .en(en), .angle(pc_reg), .sine(cp));

    // basis products, rounding, target products, sums, translation
    logic signed [63:0] p1_dx_reg, p1_dz_reg, p1_ux_reg, p1_uz_reg;
    logic signed [31:0] s1_sy_reg, s1_cy_reg, s1_sp_reg, s1_cp_reg;
    logic signed [31:0] s2_dx_reg, s2_dz_reg, s2_ux_reg, s2_uz_reg;
    logic signed [31:0] s2_sy_reg, s2_cy_reg, s2_sp_reg, s2_cp_reg;
    logic signed [63:0] p3_cyx_reg, p3_syz_reg, p3_uxx_reg, p3_cpy_reg;
    logic signed [63:0] p3_uzz_reg, p3_dxx_reg, p3_spy_reg, p3_dzz_reg;
    ocvm_pkg::mat_t     s3_reg, s4_reg, s5_reg;
    ocvm_pkg::mat_t     s5_next;
    logic signed [63:0] t0_reg, t1_reg, t2_reg;
    logic signed [65:0] n0, n1, n2;

    // translation row rounding and saturation
    always_comb begin
        n0 = (66'sd536870912 - 66'(t0_reg)) >>> 30;
        n1 = (66'sd536870912 - 66'(t1_reg)) >>> 30;
        n2 = (66'sd536870912 - 66'(t2_reg)) >>> 30;
        s5_next      = s4_reg;
        s5_next.tr_x = ocvm_pkg::sat32(n0);
        s5_next.tr_y = ocvm_pkg::sat32(n1);
        s5_next.tr_z = ocvm_pkg::sat32(n2 - $signed({35'd0, rad_reg[LAST-1]}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // forward and up products
            p1_dx_reg <= 64'(cp) * 64'(sy);
            p1_dz_reg <= 64'(cp) * 64'(cy);
            p1_ux_reg <= 64'(32'sd0 - sy) * 64'(sp);
            p1_uz_reg <= 64'(32'sd0 - cy) * 64'(sp);
            s1_sy_reg <= sy;
            s1_cy_reg <= cy;
            s1_sp_reg <= sp;
            s1_cp_reg <= cp;
            // back to Q30
            s2_dx_reg <= ocvm_pkg::rnd30(p1_dx_reg);
            s2_dz_reg <= ocvm_pkg::rnd30(p1_dz_reg);
            s2_ux_reg <= ocvm_pkg::rnd30(p1_ux_reg);
            s2_uz_reg <= ocvm_pkg::rnd30(p1_uz_reg);
            s2_sy_reg <= s1_sy_reg;
            s2_cy_reg <= s1_cy_reg;
            s2_sp_reg <= s1_sp_reg;
            s2_cp_reg <= s1_cp_reg;
            // target products and output-format unit elements
            p3_cyx_reg <= 64'(s2_cy_reg) * 64'(tgt_x_reg);
            p3_syz_reg <= 64'(s2_sy_reg) * 64'(tgt_z_reg);
            p3_uxx_reg <= 64'(s2_ux_reg) * 64'(tgt_x_reg);
            p3_cpy_reg <= 64'(s2_cp_reg) * 64'(tgt_y_reg);
            p3_uzz_reg <= 64'(s2_uz_reg) * 64'(tgt_z_reg);
            p3_dxx_reg <= 64'(s2_dx_reg) * 64'(tgt_x_reg);
            p3_spy_reg <= 64'(s2_sp_reg) * 64'(tgt_y_reg);
            p3_dzz_reg <= 64'(s2_dz_reg) * 64'(tgt_z_reg);
            s3_reg.unit_cy  <= unit_q(s2_cy_reg);
            s3_reg.unit_ux  <= unit_q(s2_ux_reg);
            s3_reg.unit_dx  <= unit_q(s2_dx_reg);
            s3_reg.unit_cp  <= unit_q(s2_cp_reg);
            s3_reg.unit_sp  <= unit_q(s2_sp_reg);
            s3_reg.unit_nsy <= unit_q(32'sd0 - s2_sy_reg);
            s3_reg.unit_uz  <= unit_q(s2_uz_reg);
            s3_reg.unit_dz  <= unit_q(s2_dz_reg);
            s3_reg.tr_x     <= '0;
            s3_reg.tr_y     <= '0;
            s3_reg.tr_z     <= '0;
            // dot product sums
            t0_reg <= p3_cyx_reg - p3_syz_reg;
            t1_reg <= p3_uxx_reg + p3_cpy_reg + p3_uzz_reg;
            t2_reg <= p3_dxx_reg + p3_spy_reg + p3_dzz_reg;
            s4_reg <= s3_reg;
            // translation row
            s5_reg <= s5_next;
        end
    end

    // row serializer
    ocvm_pkg::mat_t mat_reg;
    logic           ser_vld_next;
    logic [1:0]     row_next;

    always_comb begin
        ser_vld_next = ser_vld_reg;
        row_next     = row_reg;
        priority if (ser_load) begin
            ser_vld_next = 1'b1;
            row_next     = 2'd0;
        end else if (ser_done) begin
            ser_vld_next = 1'b0;
        end else if (ser_vld_reg && m_ready) begin
            row_next = row_reg + 2'd1;
        end else begin
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_vld_reg <= 1'b0;
            row_reg     <= '0;
        end else begin
            ser_vld_reg <= ser_vld_next;
            row_reg     <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_load) begin
            mat_reg <= s5_reg;
        end
    end

    // row select
    always_comb begin
        m_elem3 = '0;
        unique case (row_reg)
            2'd0: begin
                m_elem0 = mat_reg.unit_cy;
                m_elem1 = mat_reg.unit_ux;
                m_elem2 = mat_reg.unit_dx;
            end
            2'd1: begin
                m_elem0 = '0;
                m_elem1 = mat_reg.unit_cp;
                m_elem2 = mat_reg.unit_sp;
            end
            2'd2: begin
                m_elem0 = mat_reg.unit_nsy;
                m_elem1 = mat_reg.unit_uz;
                m_elem2 = mat_reg.unit_dz;
            end
            default: begin
                m_elem0 = mat_reg.tr_x;
                m_elem1 = mat_reg.tr_y;
                m_elem2 = mat_reg.tr_z;
                m_elem3 = ONE_F;
            end
        endcase
    end

    assign m_valid     = ser_vld_reg;
    assign m_row_index = row_reg;
    assign m_last_row  = (row_reg == ocvm_pkg::ROW_LAST);

endmodule

@@ rtl/ocvm_checker.sv @@
// ----------------------------------------------------------------------------
// ocvm_checker
// Port-level checks of the row sequence on the matrix output channel.
// ----------------------------------------------------------------------------
module ocvm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_row_index,
    input logic signed [31:0] m_elem0,
    input logic signed [31:0] m_elem3,
    input logic               m_last_row
);

    // last row flag marks row three only
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_row == (m_row_index == 2'd3)))
        else $error("last row flag does not match row index");

    // rows of one matrix follow without a gap
    a_row_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_row) |=>
        (m_valid && m_row_index == 2'($past(m_row_index) + 2'd1)))
        else $error("row sequence broken");

    // row one carries zero in its outer columns
    a_row1_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_row_index == 2'd1) |-> (m_elem0 == 32'sd0 && m_elem3 == 32'sd0))
        else $error("row one outer elements not zero");

    // a stalled row holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_row_index) && $stable(m_elem0)))
        else $error("stalled row changed");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind orbit_camera_view_matrix ocvm_checker u_ocvm_checker (.*);

@@ dv/orbit_camera_view_matrix_checker.sv @@
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix_checker
// Watches the update and row channels and the register port, computes the
// expected view-matrix rows for every accepted update and compares them with
// each row transfer in order.
// ----------------------------------------------------------------------------
module orbit_camera_view_matrix_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_yaw_angle,
    input  logic signed [14:0] s_pitch_angle,
    input  logic [30:0]        s_orbit_radius,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_row_index,
    input  logic signed [31:0] m_elem0,
    input  logic signed [31:0] m_elem1,
    input  logic signed [31:0] m_elem2,
    input  logic signed [31:0] m_elem3,
    input  logic               m_last_row,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending_rows,
    output int                 rows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] e0;
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic signed [31:0] e3;
        logic               last;
    } row_t;

    row_t             expected_rows[$];
    logic signed [63:0] tgt_x, tgt_y, tgt_z;

    // divide by 2^sh rounding half up (arithmetic shift floors)
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic signed [63:0] h;
        h = 64'sd1 <<< sh;
        return (v + (h >>> 1)) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // quarter-wave sine, Q30, a in 0..9000
    function automatic logic signed [63:0] quarter_sine(input int unsigned a);
        logic [63:0] x, x2, t;
        int unsigned divs[5];
        divs = '{110, 72, 42, 20, 6};
        x  = (64'(a) * 64'd3373259426 + 64'd9000) / 64'd18000;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int i = 0; i < 5; i++)
            t = 64'd1073741824 - (((x2 * t) >> 30) / 64'(divs[i]));
        return $signed((x * t) >> 30);
    endfunction

    function automatic logic signed [63:0] wave_sine(input int unsigned a);
        if (a < 9000) return quarter_sine(a);
        if (a < 18000) return quarter_sine(18000 - a);
        if (a < 27000) return -quarter_sine(a - 18000);
        return -quarter_sine(36000 - a);
    endfunction

    function automatic logic signed [31:0] unit_elem(input logic signed [63:0] v);
        return clamp32(round_shift(v, 30 - FRAC_BITS));
    endfunction

    // build the four rows of the view matrix for one update
    task automatic predict_matrix(input logic signed [15:0] yaw_in,
                                  input logic signed [14:0] pitch_in,
                                  input logic [30:0] radius_in);
        int yaw, pitch;
        logic signed [63:0] sy, cy, sp, cp, dx, dz, ux, uz, acc, rad, rmin;
        row_t r;
        yaw = int'(yaw_in) % 36000;
        if (yaw < 0) yaw += 36000;
        pitch = int'(pitch_in);
        if (pitch > 8900) pitch = 8900;
        if (pitch < -8900) pitch = -8900;
        if (pitch < 0) pitch += 36000;
        rmin = ((64'sd1 <<< FRAC_BITS) + 5) / 10;
        rad = $signed({33'd0, radius_in});
        if (rad < rmin) rad = rmin;
        sy = wave_sine(yaw);
        cy = wave_sine((yaw + 9000) % 36000);
        sp = wave_sine(pitch);
        cp = wave_sine((pitch + 9000) % 36000);
        dx = round_shift(cp * sy, 30);
        dz = round_shift(cp * cy, 30);
        ux = round_shift(-sy * sp, 30);
        uz = round_shift(-cy * sp, 30);
        r = '{2'd0, unit_elem(cy), unit_elem(ux), unit_elem(dx), 32'sd0, 1'b0};
        expected_rows.push_back(r);
        r = '{2'd1, 32'sd0, unit_elem(cp), unit_elem(sp), 32'sd0, 1'b0};
        expected_rows.push_back(r);
        r = '{2'd2, unit_elem(-sy), unit_elem(uz), unit_elem(dz), 32'sd0, 1'b0};
        expected_rows.push_back(r);
        r.row  = ocvm_pkg::ROW_LAST;
        r.last = 1'b1;
        acc  = cy * tgt_x - sy * tgt_z;
        r.e0 = clamp32(round_shift(-acc, 30));
        acc  = ux * tgt_x + cp * tgt_y + uz * tgt_z;
        r.e1 = clamp32(round_shift(-acc, 30));
        acc  = dx * tgt_x + sp * tgt_y + dz * tgt_z;
        r.e2 = clamp32(round_shift(-acc, 30) - rad);
        r.e3 = 32'sd1 <<< FRAC_BITS;
        expected_rows.push_back(r);
    endtask

    // register writes, update transfers and row transfers
    always @(posedge aclk) begin
        row_t e;
        if (!aresetn) begin
            tgt_x = 0;
            tgt_y = 0;
            tgt_z = 0;
            expected_rows.delete();
            fail_count   = 0;
            rows_seen    = 0;
            pending_rows = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    ocvm_pkg::REG_TARGET_X: tgt_x = $signed(pwdata);
                    ocvm_pkg::REG_TARGET_Y: tgt_y = $signed(pwdata);
                    ocvm_pkg::REG_TARGET_Z: tgt_z = $signed(pwdata);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                rows_seen++;
                if (expected_rows.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected row transfer: row %0d", m_row_index);
                end else begin
                    e = expected_rows.pop_front();
                    if (e.row !== m_row_index || e.e0 !== m_elem0 || e.e1 !== m_elem1
                        || e.e2 !== m_elem2 || e.e3 !== m_elem3
                        || e.last !== m_last_row) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("row mismatch exp row=%0d %0d %0d %0d %0d last=%0d",
                                     e.row, e.e0, e.e1, e.e2, e.e3, e.last);
                            $display("             got row=%0d %0d %0d %0d %0d last=%0d",
                                     m_row_index, m_elem0, m_elem1, m_elem2, m_elem3,
                                     m_last_row);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                predict_matrix(s_yaw_angle, s_pitch_angle, s_orbit_radius);
            pending_rows = expected_rows.size();
        end
    end
endmodule

@@ dv/orbit_camera_view_matrix_tb.sv @@
// ----------------------------------------------------------------------------
// orbit_camera_view_matrix_tb
// Drives camera updates and target register writes into the view-matrix block
// with random gaps and row stalls; the checker judges every row.
// ----------------------------------------------------------------------------
module orbit_camera_view_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_yaw_angle;
    logic signed [14:0] s_pitch_angle;
    logic [30:0]        s_orbit_radius;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_row_index;
    logic signed [31:0] m_elem0, m_elem1, m_elem2, m_elem3;
    logic               m_last_row;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    int                 fail_count, pending_rows, rows_seen;
    int                 updates_sent;

    orbit_camera_view_matrix DUT (.*);

    orbit_camera_view_matrix_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("orbit_camera_view_matrix regression: fail");
        $finish;
    end

    // row stalls: random hold-offs before each ready, with calm stretches
    initial begin
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic write_target(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // valid stays up across a back-to-back transfer and drops over a gap
    task automatic send_update(input logic [15:0] yaw, input logic [14:0] pitch,
                               input logic [30:0] radius, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_yaw_angle    <= yaw;
        s_pitch_angle  <= pitch;
        s_orbit_radius <= radius;
        @(posedge aclk iff s_ready);
        updates_sent++;
    endtask

    task automatic drain_rows();
        s_valid <= 1'b0;
        @(posedge aclk iff pending_rows == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_targets(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        write_target(ocvm_pkg::REG_TARGET_X, x);
        write_target(ocvm_pkg::REG_TARGET_Y, y);
        write_target(ocvm_pkg::REG_TARGET_Z, z);
    endtask

    initial begin
        logic [15:0] yaw;
        logic [14:0] pitch;
        logic [30:0] radius;
        bit burst;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_yaw_angle = '0;
        s_pitch_angle = '0;
        s_orbit_radius = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        updates_sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, wraps, clamps, quadrant edges
        send_update(16'sd0, 15'sd0, 31'd65536, 1'b0);
        send_update(16'sh7fff, 15'sh3fff, 31'h7fffffff, 1'b0);
        send_update(16'sh8000, 15'sh4000, 31'd0, 1'b0);
        send_update(16'sd17999, 15'sd8900, 31'd6554, 1'b0);
        send_update(-16'sd18000, -15'sd8900, 31'd6553, 1'b0);
        send_update(16'sd9000, 15'sd8901, 31'd1, 1'b0);
        send_update(-16'sd9000, -15'sd8901, 31'd100000, 1'b0);
        send_update(16'sd27000, 15'sd4500, 31'd65536, 1'b1);
        send_update(16'sd18000, -15'sd4500, 31'd65536, 1'b1);
        send_update(16'sd36000, 15'sd1, 31'd300000, 1'b1);
        drain_rows();
        set_targets(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_update(16'sd4500, 15'sd8900, 31'h7fffffff, 1'b0);
        send_update(16'sd13500, -15'sd8900, 31'h7fffffff, 1'b0);
        send_update(-16'sd4500, 15'sd0, 31'd6554, 1'b0);
        drain_rows();
        set_targets(32'h80000000, 32'h7fffffff, 32'h80000000);
        send_update(16'sd22500, 15'sd8900, 31'h7fffffff, 1'b0);
        send_update(16'sd0, -15'sd8900, 31'h7fffffff, 1'b0);
        drain_rows();

        // random phases, each with its own target
        for (int phase = 0; phase < 6; phase++) begin
            set_targets($urandom(), $urandom(), $urandom());
            for (int i = 0; i < 32; i++) begin
                burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0) begin
                    yaw = 16'($urandom());
                    pitch = 15'($urandom());
                end else begin
                    yaw = 16'($urandom_range(0, 35999) - 18000);
                    pitch = 15'($urandom_range(0, 17800) - 8900);
                end
                case ($urandom_range(0, 3))
                    0: radius = 31'($urandom());
                    1: radius = 31'($urandom_range(0, 7000));
                    default: radius = 31'($urandom_range(6554, 1 << 24));
                endcase
                send_update(yaw, pitch, radius, burst);
                // sender holds off until every row is back
                if (i == 16) begin
                    s_valid <= 1'b0;
                    @(posedge aclk iff pending_rows == 0);
                end
            end
            drain_rows();
        end
        set_targets(32'd0, 32'd0, 32'd0);
        send_update(16'sd1234, -15'sd2345, 31'd65536, 1'b0);
        drain_rows();

        $display("covered %0d camera updates and %0d matrix rows over 9 target settings",
                 updates_sent, rows_seen);
        if (fail_count == 0) begin
            $display("orbit_camera_view_matrix regression: pass");
        end else begin
            $display("orbit_camera_view_matrix regression: fail");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/ocvm_pkg.sv
rtl/ocvm_sine.sv
rtl/orbit_camera_view_matrix.sv
rtl/ocvm_checker.sv
dv/orbit_camera_view_matrix_checker.sv
dv/orbit_camera_view_matrix_tb.sv
